// ===== src/wscp_pkg.sv =====
// Shared types and constants of the windowed spike count packer.
package wscp_pkg;

  localparam int FLAGS_W = 30;
  localparam int CNT_W   = 5;
  localparam int WORD_W  = 50;
  localparam int EPOCH_W = 10;
  localparam int BITS_W  = 3;
  localparam int CFG_W   = 10;
  localparam int MASK_W  = 3;
  localparam int NUM_WORDS = 3;

  // Configuration register indexes
  localparam logic CFG_EPOCH_LENGTH   = 1'b0;
  localparam logic CFG_BITS_PER_COUNT = 1'b1;

  // Reset values
  localparam logic [EPOCH_W-1:0] EPOCH_RST = 10'd10;
  localparam logic [BITS_W-1:0]  BITS_RST  = 3'd3;
  localparam logic [EPOCH_W-1:0] PHASE_RST = 10'd1;

  // Field widths
  localparam logic [BITS_W-1:0] BITS_MIN = 3'd3;
  localparam logic [BITS_W-1:0] BITS_MID = 3'd4;
  localparam logic [BITS_W-1:0] BITS_MAX = 3'd5;

  // Phases of interest
  localparam logic [EPOCH_W-1:0] PHASE_COUNT_ABOVE = 10'd4;
  localparam logic [EPOCH_W-1:0] PHASE_GRP_A       = 10'd7;
  localparam logic [EPOCH_W-1:0] PHASE_GRP_B       = 10'd8;
  localparam logic [EPOCH_W-1:0] PHASE_GRP_C       = 10'd1;

  typedef struct packed {
    logic              step;      // a request is taken this cycle
    logic              count_en;  // phase lets spikes be counted
    logic              clear;     // phase 0: clear counts after packing
  } cnt_ctl_t;

  typedef struct packed {
    logic              words_valid;
    logic [WORD_W-1:0] word_low;
    logic [WORD_W-1:0] word_mid;
    logic [WORD_W-1:0] word_high;
    logic [MASK_W-1:0] mask;
  } result_t;

  // Largest count a field of the given (effective) width holds
  function automatic logic [CNT_W-1:0] field_max(input logic [BITS_W-1:0] bits);
    logic [CNT_W-1:0] m;
    unique case (bits)
      BITS_MIN: m = 5'd7;
      BITS_MID: m = 5'd15;
      default:  m = 5'd31;
    endcase
    return m;
  endfunction

endpackage

// ===== src/windowed_spike_count_packer_core.sv =====
// Windowed spike count packer: takes one network time step per request, each
// carrying one spike flag per output neuron, and returns exactly one result per
// step. A phase counter runs modulo epoch_length (reset phase 1). Spikes are
// counted in phase 0 and in phases above 4, each neuron in its own counter that
// holds at the field maximum 2^bits_per_count - 1 (bits_per_count clamped to
// 3..5). In phase 0 the counts are packed ten to a word into packed_word_low,
// _mid and _high, lowest neuron in the least significant field, and then
// cleared; outside phase 0 the words read zero. reset_group_mask flags the
// core groups needing a hard reset: bit 0 in phases 7 and 8, bit 1 in phases
// 8 and 0, bit 2 in phases 0 and 1. A phase at or beyond epoch_length is
// treated as phase 0. Rate: one request per clock unless the queue is full; the
// counters, packer and mask update together, and the result is available from
// the cycle after the request. A two-entry result queue lets a new request be
// taken while an earlier result still waits, so spike_ready only drops after two
// results have gone unclaimed. Write configuration only while the block is idle.
module windowed_spike_count_packer_core #(
  parameter int NEURONS         = 30,
  parameter int COUNTS_PER_WORD = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [wscp_pkg::CFG_W-1:0]       cfg_data,
  // step requests
  input  logic                             spike_valid,
  output logic                             spike_ready,
  input  logic [wscp_pkg::FLAGS_W-1:0]     spike_flags,
  // results
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic                             words_valid,
  output logic [wscp_pkg::WORD_W-1:0]      packed_word_low,
  output logic [wscp_pkg::WORD_W-1:0]      packed_word_mid,
  output logic [wscp_pkg::WORD_W-1:0]      packed_word_high,
  output logic [wscp_pkg::MASK_W-1:0]      reset_group_mask
);

  // Configuration and phase registers
  logic [wscp_pkg::EPOCH_W-1:0] epoch_length;
  logic [wscp_pkg::BITS_W-1:0]  bits_per_count;
  logic [wscp_pkg::EPOCH_W-1:0] step_phase;
  logic [wscp_pkg::EPOCH_W-1:0] step_phase_next;

  logic [wscp_pkg::EPOCH_W-1:0] phase;      // effective phase of this step
  logic [wscp_pkg::EPOCH_W:0]   phase_inc;  // one bit wider, so it can reach the epoch
  logic [wscp_pkg::BITS_W-1:0]  eff_bits;
  logic [wscp_pkg::CNT_W-1:0]   maxc;
  logic                         phase_zero;
  logic                         step;

  wscp_pkg::cnt_ctl_t                         cnt_ctl;
  logic [NEURONS-1:0][wscp_pkg::CNT_W-1:0]    cnt_upd;
  logic [wscp_pkg::WORD_W-1:0]                word_low;
  logic [wscp_pkg::WORD_W-1:0]                word_mid;
  logic [wscp_pkg::WORD_W-1:0]                word_high;
  wscp_pkg::result_t                          res;
  wscp_pkg::result_t                          res_out;
  logic                                       q_full;

  assign step = spike_valid && spike_ready;

  // Treat a phase at or past the epoch length as phase 0
  assign phase      = (step_phase < epoch_length) ? step_phase : '0;
  assign phase_zero = (phase == '0);
  assign phase_inc  = {1'b0, phase} + 11'd1;
  assign step_phase_next = (phase_inc >= {1'b0, epoch_length}) ?
                           '0 : phase_inc[wscp_pkg::EPOCH_W-1:0];

  // Clamp the field width to the supported range
  always_comb begin
    priority if (bits_per_count < wscp_pkg::BITS_MIN) begin
      eff_bits = wscp_pkg::BITS_MIN;
    end else if (bits_per_count > wscp_pkg::BITS_MAX) begin
      eff_bits = wscp_pkg::BITS_MAX;
    end else begin
      eff_bits = bits_per_count;
    end
  end
  assign maxc = wscp_pkg::field_max(eff_bits);

  assign cnt_ctl.step     = step;
  assign cnt_ctl.count_en = phase_zero || (phase > wscp_pkg::PHASE_COUNT_ABOVE);
  assign cnt_ctl.clear    = phase_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_length   <= wscp_pkg::EPOCH_RST;
      bits_per_count <= wscp_pkg::BITS_RST;
      step_phase     <= wscp_pkg::PHASE_RST;
    end else begin
      if (cfg_we && cfg_index == wscp_pkg::CFG_EPOCH_LENGTH) begin
        epoch_length <= cfg_data[wscp_pkg::EPOCH_W-1:0];
      end
      if (cfg_we && cfg_index == wscp_pkg::CFG_BITS_PER_COUNT) begin
        bits_per_count <= cfg_data[wscp_pkg::BITS_W-1:0];
      end
      // Advance the phase once per accepted step
      if (step) begin
        step_phase <= step_phase_next;
      end
    end
  end

  wscp_counts #(
    .NEURONS (NEURONS)
  ) u_counts (
    .clk     (clk),
    .rst     (rst),
    .ctl     (cnt_ctl),
    .flags   (spike_flags),
    .maxc    (maxc),
    .cnt_upd (cnt_upd)
  );

  // Pack the counts including this step's spikes
  wscp_pack #(
    .NEURONS         (NEURONS),
    .COUNTS_PER_WORD (COUNTS_PER_WORD)
  ) u_pack (
    .cnt       (cnt_upd),
    .bits      (eff_bits),
    .maxc      (maxc),
    .word_low  (word_low),
    .word_mid  (word_mid),
    .word_high (word_high)
  );

  // Assemble the result; drop the words outside phase 0
  always_comb begin
    res.words_valid = phase_zero;
    res.word_low    = phase_zero ? word_low  : '0;
    res.word_mid    = phase_zero ? word_mid  : '0;
    res.word_high   = phase_zero ? word_high : '0;
    res.mask[0]     = (phase == wscp_pkg::PHASE_GRP_A) || (phase == wscp_pkg::PHASE_GRP_B);
    res.mask[1]     = (phase == wscp_pkg::PHASE_GRP_B) || phase_zero;
    res.mask[2]     = phase_zero || (phase == wscp_pkg::PHASE_GRP_C);
  end

  wscp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (res),
    .full      (q_full),
    .pop_ready (result_ready),
    .out_valid (result_valid),
    .out_data  (res_out)
  );

  assign spike_ready      = !q_full;
  assign words_valid      = res_out.words_valid;
  assign packed_word_low  = res_out.word_low;
  assign packed_word_mid  = res_out.word_mid;
  assign packed_word_high = res_out.word_high;
  assign reset_group_mask = res_out.mask;

  a_words_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !words_valid |->
      (packed_word_low == '0) && (packed_word_mid == '0) && (packed_word_high == '0))
    else $error("packed words present outside phase 0");
  a_phase0_mask: assert property (@(posedge clk) disable iff (rst)
    result_valid && words_valid |-> reset_group_mask[1] && reset_group_mask[2])
    else $error("phase 0 result lacks its reset groups");
  a_mask_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(reset_group_mask[0] && reset_group_mask[2]))
    else $error("reset groups 0 and 2 flagged together");
  a_phase_wrap: assert property (@(posedge clk) disable iff (rst)
    step && phase_zero && (epoch_length > 10'd1) |=> step_phase == 10'd1)
    else $error("phase did not move on from 0");

endmodule

// ===== src/wscp_counts.sv =====
// Bank of saturating per-neuron spike counters.
module wscp_counts #(
  parameter int NEURONS = 30
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  wscp_pkg::cnt_ctl_t                        ctl,
  input  logic [wscp_pkg::FLAGS_W-1:0]              flags,
  input  logic [wscp_pkg::CNT_W-1:0]                maxc,
  output logic [NEURONS-1:0][wscp_pkg::CNT_W-1:0]   cnt_upd
);

  logic [NEURONS-1:0][wscp_pkg::CNT_W-1:0] cnt;

  // Raise each count by one when its neuron fired, holding at the field maximum
  always_comb begin
    for (int i = 0; i < NEURONS; i++) begin
      if (ctl.count_en && flags[i] && (cnt[i] < maxc)) begin
        cnt_upd[i] = cnt[i] + 5'd1;
      end else begin
        cnt_upd[i] = cnt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.step) begin
      cnt <= ctl.clear ? '0 : cnt_upd;
    end
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.step && ctl.clear |=> cnt == '0)
    else $error("counts not cleared after phase 0");

endmodule

// ===== src/wscp_pack.sv =====
// Packs the counts into three words at the selected field width.
module wscp_pack #(
  parameter int NEURONS         = 30,
  parameter int COUNTS_PER_WORD = 10
) (
  input  logic [NEURONS-1:0][wscp_pkg::CNT_W-1:0] cnt,
  input  logic [wscp_pkg::BITS_W-1:0]             bits,
  input  logic [wscp_pkg::CNT_W-1:0]              maxc,
  output logic [wscp_pkg::WORD_W-1:0]             word_low,
  output logic [wscp_pkg::WORD_W-1:0]             word_mid,
  output logic [wscp_pkg::WORD_W-1:0]             word_high
);

  localparam int NW = wscp_pkg::NUM_WORDS;

  logic [NW-1:0][COUNTS_PER_WORD-1:0][wscp_pkg::CNT_W-1:0] fc;
  logic [NW-1:0][wscp_pkg::WORD_W-1:0]                     words;

  // Clamp each count to the current field maximum
  for (genvar w = 0; w < NW; w++) begin : g_word
    for (genvar j = 0; j < COUNTS_PER_WORD; j++) begin : g_field
      localparam int N = w * COUNTS_PER_WORD + j;
      if (N < NEURONS) begin : g_used
        assign fc[w][j] = (cnt[N] > maxc) ? maxc : cnt[N];
      end else begin : g_none
        assign fc[w][j] = '0;
      end
    end
  end

  always_comb begin
    words = '0;
    for (int w = 0; w < NW; w++) begin
      for (int j = 0; j < COUNTS_PER_WORD; j++) begin
        unique case (bits)
          wscp_pkg::BITS_MIN: words[w][j*3 +: 3] = fc[w][j][2:0];
          wscp_pkg::BITS_MID: words[w][j*4 +: 4] = fc[w][j][3:0];
          default:            words[w][j*5 +: 5] = fc[w][j];
        endcase
      end
    end
  end

  assign word_low  = words[0];
  assign word_mid  = words[1];
  assign word_high = words[2];

endmodule

// ===== src/wscp_outq.sv =====
// Two-entry result queue that parts the input side from the output side.
module wscp_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wscp_pkg::result_t  push_data,
  output logic               full,
  input  logic               pop_ready,
  output logic               out_valid,
  output wscp_pkg::result_t  out_data
);

  wscp_pkg::result_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       pop;

  assign out_valid = (fill != 2'd0);
  assign full      = (fill == 2'd2);
  assign pop       = out_valid && pop_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill out of range");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> fill == $past(fill) + 2'd1)
    else $error("queue fill did not grow on push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd1) |-> (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with fill");

endmodule

// ===== bench/windowed_spike_count_packer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the windowed spike count packer core.
module testbench;

  localparam int N_NEURONS       = 30;
  localparam int FIELDS_PER_WORD = 10;
  localparam int STALL_LIMIT     = 1000;  // cycles with no handshake before giving up
  localparam int TAIL_CYCLES     = 20;    // quiet cycles after the last result
  localparam int RANDOM_EPOCHS   = 6;
  localparam int RANDOM_STEPS    = 60;

  localparam logic [wscp_pkg::FLAGS_W-1:0] ALL_FLAGS = {wscp_pkg::FLAGS_W{1'b1}};
  // Every field holding a count of six at 3-bit width
  localparam logic [wscp_pkg::WORD_W-1:0]  SIXES     = 50'o6666666666;

  // Results that can be read straight off the phase
  localparam wscp_pkg::result_t R_NONE   = '{1'b0, 50'd0, 50'd0, 50'd0, 3'b000};
  localparam wscp_pkg::result_t R_GRP_C  = '{1'b0, 50'd0, 50'd0, 50'd0, 3'b100};
  localparam wscp_pkg::result_t R_GRP_A  = '{1'b0, 50'd0, 50'd0, 50'd0, 3'b001};
  localparam wscp_pkg::result_t R_GRP_AB = '{1'b0, 50'd0, 50'd0, 50'd0, 3'b011};
  localparam wscp_pkg::result_t R_PACK6  = '{1'b1, SIXES, SIXES, SIXES, 3'b110};

  typedef struct packed {
    logic [wscp_pkg::FLAGS_W-1:0] flags;
    logic                         pinned;  // result typed in below rather than predicted
    wscp_pkg::result_t            want;
  } step_row_t;

  typedef struct packed {
    logic [wscp_pkg::EPOCH_W-1:0] epoch;
    logic [wscp_pkg::BITS_W-1:0]  bits;
    logic [9:0]                   steps;
    logic                         dense;   // mostly set flags, so counts reach saturation
  } epoch_plan_t;

  // Opening steps from reset (phase 1, epoch 10, 3-bit fields). The first epoch
  // fires every neuron on every step but the second, so phase 0 packs a count of
  // six in every field; the second epoch uses mixed patterns and is predicted.
  localparam step_row_t OPENING_STEPS [20] = '{
    '{ALL_FLAGS,      1'b1, R_GRP_C},   // phase 1: no counting, core 2 reset
    '{30'h0000_0000, 1'b1, R_NONE},
    '{ALL_FLAGS,      1'b1, R_NONE},    // phases 2 to 4 ignore spikes
    '{ALL_FLAGS,      1'b1, R_NONE},
    '{ALL_FLAGS,      1'b1, R_NONE},    // phase 5: counting starts
    '{ALL_FLAGS,      1'b1, R_NONE},
    '{ALL_FLAGS,      1'b1, R_GRP_A},
    '{ALL_FLAGS,      1'b1, R_GRP_AB},
    '{ALL_FLAGS,      1'b1, R_NONE},
    '{ALL_FLAGS,      1'b1, R_PACK6},   // phase 0: six counted steps packed
    '{30'h0000_0000, 1'b1, R_GRP_C},   // counts cleared
    '{30'h2AAA_AAAA, 1'b0, R_NONE},
    '{30'h1555_5555, 1'b0, R_NONE},
    '{ALL_FLAGS,      1'b0, R_NONE},
    '{30'h2AAA_AAAA, 1'b0, R_NONE},
    '{30'h1555_5555, 1'b0, R_NONE},
    '{30'h0000_0001, 1'b0, R_NONE},    // lowest neuron alone
    '{30'h2000_0000, 1'b0, R_NONE},    // highest neuron alone
    '{ALL_FLAGS,      1'b0, R_NONE},
    '{30'h0000_0000, 1'b0, R_NONE}
  };

  // Register settings walked after the opening steps, phase carried across
  localparam epoch_plan_t EPOCH_PLAN [8] = '{
    '{10'd9,    3'd3, 10'd40,  1'b0},  // shortest legal epoch
    '{10'd40,   3'd5, 10'd100, 1'b1},  // long epoch: 5-bit counts saturate
    '{10'd40,   3'd3, 10'd60,  1'b1},  // narrowed mid-epoch: large counts clip
    '{10'd1023, 3'd4, 10'd30,  1'b0},  // longest epoch, phase runs far out
    '{10'd20,   3'd4, 10'd80,  1'b1},  // phase left beyond the new epoch
    '{10'd0,    3'd0, 10'd30,  1'b0},  // zero epoch; width clamps up to 3
    '{10'd1,    3'd7, 10'd30,  1'b1},  // one-step epoch; width clamps down to 5
    '{10'd2,    3'd6, 10'd30,  1'b0}
  };

  logic                           clk;
  logic                           rst          = 1'b1;
  logic                           cfg_we       = 1'b0;
  logic                           cfg_index    = wscp_pkg::CFG_EPOCH_LENGTH;
  logic [wscp_pkg::CFG_W-1:0]     cfg_data     = '0;
  logic                           spike_valid  = 1'b0;
  logic                           spike_ready;
  logic [wscp_pkg::FLAGS_W-1:0]   spike_flags  = '0;
  logic                           result_valid;
  logic                           result_ready = 1'b0;
  logic                           words_valid;
  logic [wscp_pkg::WORD_W-1:0]    packed_word_low;
  logic [wscp_pkg::WORD_W-1:0]    packed_word_mid;
  logic [wscp_pkg::WORD_W-1:0]    packed_word_high;
  logic [wscp_pkg::MASK_W-1:0]    reset_group_mask;

  // Travels with each request: a typed-in result replaces the prediction
  logic                           step_pinned  = 1'b0;
  wscp_pkg::result_t              step_want    = '0;

  bit                             gaps_on      = 1'b1;  // sender may pause between requests
  bit                             calm         = 1'b0;  // closing stretch: no pauses at all
  int unsigned                    mismatches   = 0;
  int unsigned                    stall_cycles = 0;

  // Mirror of the block's state
  logic [wscp_pkg::CNT_W-1:0]     spike_tally [N_NEURONS];
  logic [wscp_pkg::EPOCH_W-1:0]   phase_now;
  logic [wscp_pkg::EPOCH_W-1:0]   epoch_reg;
  logic [wscp_pkg::BITS_W-1:0]    width_reg;
  wscp_pkg::result_t              pending_words [$];

  windowed_spike_count_packer_core dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .spike_valid      (spike_valid),
    .spike_ready      (spike_ready),
    .spike_flags      (spike_flags),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .words_valid      (words_valid),
    .packed_word_low  (packed_word_low),
    .packed_word_mid  (packed_word_mid),
    .packed_word_high (packed_word_high),
    .reset_group_mask (reset_group_mask)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the mirrored state by one time step and return its result.
  function automatic wscp_pkg::result_t pack_step(input logic [wscp_pkg::FLAGS_W-1:0] flags);
    wscp_pkg::result_t            r;
    logic [wscp_pkg::EPOCH_W-1:0] ph;
    int unsigned                  fw;
    int unsigned                  top;
    int unsigned                  c;
    logic [wscp_pkg::WORD_W-1:0]  field;
    logic [wscp_pkg::WORD_W-1:0]  word [wscp_pkg::NUM_WORDS];
    r    = '0;
    word = '{default: '0};
    // A phase at or past the epoch length behaves as phase 0
    ph   = (phase_now < epoch_reg) ? phase_now : '0;
    fw   = (width_reg < wscp_pkg::BITS_MIN) ? 32'(wscp_pkg::BITS_MIN) :
           (width_reg > wscp_pkg::BITS_MAX) ? 32'(wscp_pkg::BITS_MAX) : 32'(width_reg);
    top  = (1 << fw) - 1;
    // Count in phase 0 and past the lead-in phases; hold at the field maximum
    if (ph > wscp_pkg::PHASE_COUNT_ABOVE || ph == '0) begin
      for (int i = 0; i < N_NEURONS; i++) begin
        if (flags[i] && spike_tally[i] < top) spike_tally[i] = spike_tally[i] + 1'b1;
      end
    end
    if (ph == '0) begin
      r.words_valid = 1'b1;
      for (int i = 0; i < N_NEURONS; i++) begin
        // A count left over from a wider setting is clipped to the field
        c     = (spike_tally[i] > top) ? top : 32'(spike_tally[i]);
        field = wscp_pkg::WORD_W'(c);
        word[i / FIELDS_PER_WORD] |= field << ((i % FIELDS_PER_WORD) * fw);
      end
      foreach (spike_tally[i]) spike_tally[i] = '0;
    end
    r.word_low  = word[0];
    r.word_mid  = word[1];
    r.word_high = word[2];
    r.mask[0]   = (ph == wscp_pkg::PHASE_GRP_A) || (ph == wscp_pkg::PHASE_GRP_B);
    r.mask[1]   = (ph == wscp_pkg::PHASE_GRP_B) || (ph == '0);
    r.mask[2]   = (ph == '0) || (ph == wscp_pkg::PHASE_GRP_C);
    phase_now   = (int'(ph) + 1 >= int'(epoch_reg)) ? '0 : ph + 1'b1;
    return r;
  endfunction

  function automatic logic [wscp_pkg::FLAGS_W-1:0] spike_pattern(input logic dense);
    logic [wscp_pkg::FLAGS_W-1:0] a;
    logic [wscp_pkg::FLAGS_W-1:0] b;
    logic [wscp_pkg::FLAGS_W-1:0] c;
    a = wscp_pkg::FLAGS_W'($urandom);
    b = wscp_pkg::FLAGS_W'($urandom);
    c = wscp_pkg::FLAGS_W'($urandom);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ALL_FLAGS;
      default: return dense ? ~(a & b & c) : a;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Offer one step request and hold it until the block takes it.
  task automatic push_step(input logic [wscp_pkg::FLAGS_W-1:0] flags, input logic pinned,
                           input wscp_pkg::result_t want);
    int unsigned gap;
    if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      spike_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    spike_valid <= 1'b1;
    spike_flags <= flags;
    step_pinned <= pinned;
    step_want   <= want;
    @(posedge clk);
    while (!spike_ready) @(posedge clk);
  endtask

  // Drop valid and hold off until every expected result has been collected.
  task automatic settle();
    spike_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Write both registers back to back; junk above bit 2 of the width must be ignored.
  task automatic apply_setting(input logic [wscp_pkg::EPOCH_W-1:0] epoch,
                               input logic [wscp_pkg::BITS_W-1:0] bits);
    cfg_we    <= 1'b1;
    cfg_index <= wscp_pkg::CFG_EPOCH_LENGTH;
    cfg_data  <= epoch;
    @(posedge clk);
    cfg_index <= wscp_pkg::CFG_BITS_PER_COUNT;
    cfg_data  <= {7'($urandom), bits};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Scoreboard: mirror register writes, predict on each accepted request and
  // compare each collected result with the oldest prediction.
  always @(posedge clk) begin : scoreboard
    wscp_pkg::result_t want;
    if (rst) begin
      epoch_reg = wscp_pkg::EPOCH_RST;
      width_reg = wscp_pkg::BITS_RST;
      phase_now = wscp_pkg::PHASE_RST;
      foreach (spike_tally[i]) spike_tally[i] = '0;
      pending_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wscp_pkg::CFG_EPOCH_LENGTH:   epoch_reg = cfg_data[wscp_pkg::EPOCH_W-1:0];
          wscp_pkg::CFG_BITS_PER_COUNT: width_reg = cfg_data[wscp_pkg::BITS_W-1:0];
          default: ;
        endcase
      end
      if (spike_valid && spike_ready) begin
        want = pack_step(spike_flags);
        pending_words.push_back(step_pinned ? step_want : want);
      end
      if (result_valid && result_ready) begin
        if (pending_words.size() == 0) begin
          $error("result collected with no request outstanding");
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          check_field("words_valid",      64'(want.words_valid), 64'(words_valid));
          check_field("packed_word_low",  64'(want.word_low),    64'(packed_word_low));
          check_field("packed_word_mid",  64'(want.word_mid),    64'(packed_word_mid));
          check_field("packed_word_high", 64'(want.word_high),   64'(packed_word_high));
          check_field("reset_group_mask", 64'(want.mask),        64'(reset_group_mask));
        end
      end
    end
  end

  // Receiver: stall at random between runs of readiness.
  initial begin : result_sink
    int unsigned n;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 14);
        result_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result_ready <= 1'b1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin : watchdog
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst || cfg_we || (spike_valid && spike_ready) ||
                 (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Opening steps on the reset settings
    foreach (OPENING_STEPS[k]) begin
      push_step(OPENING_STEPS[k].flags, OPENING_STEPS[k].pinned, OPENING_STEPS[k].want);
    end

    // Planned settings, extremes and out-of-range values among them
    foreach (EPOCH_PLAN[k]) begin
      settle();
      apply_setting(EPOCH_PLAN[k].epoch, EPOCH_PLAN[k].bits);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (EPOCH_PLAN[k].steps) begin
        push_step(spike_pattern(EPOCH_PLAN[k].dense), 1'b0, R_NONE);
      end
    end

    // Random legal settings; the last stretch runs without any pauses
    for (int k = 0; k < RANDOM_EPOCHS; k++) begin
      settle();
      apply_setting(wscp_pkg::EPOCH_W'($urandom_range(9, 64)),
                    wscp_pkg::BITS_W'($urandom_range(3, 5)));
      calm    = (k == RANDOM_EPOCHS - 1);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (RANDOM_STEPS) begin
        push_step(spike_pattern(1'($urandom_range(0, 1))), 1'b0, R_NONE);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
